/* hw/rtl/cpt_pkg.sv */
// Shared constants, payload types and control structs of the cruise PID throttle core.
// Used by the channel interfaces, the serial arithmetic units, the top level and the checker.
`default_nettype none

package cpt_pkg;

	// Field widths
	localparam int RPM_W      = 16;
	localparam int RATIO_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int OUT_W      = 16;
	localparam int SPD_W      = 8;
	localparam int TIME_W     = 32;
	localparam int INT_W      = 32;
	localparam int ERR_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Loop constants
	localparam int TARGET_STEP = 1;
	localparam int DT_LIMIT    = 20;
	localparam int DT_REPLACE  = 10;
	localparam int D_SCALE     = 100;
	localparam int FRAC_W      = 8;

	// Derived widths
	localparam int DT_W     = $clog2(((DT_LIMIT > DT_REPLACE) ? DT_LIMIT : DT_REPLACE) + 1);
	localparam int DIFF_W   = ERR_W + 1;
	localparam int D100_W   = DIFF_W + $clog2(D_SCALE + 1);
	localparam int ED_W     = ERR_W + DT_W + 1;
	localparam int MCAND_W  = INT_W;
	localparam int MPLIER_W = GAIN_W;
	localparam int PROD_W   = MCAND_W + MPLIER_W;
	localparam int DIVD_W   = GAIN_W + D100_W - 1;
	localparam int SUM_W    = PROD_W + 2;
	localparam int SCL_W    = SUM_W - FRAC_W;
	localparam int STEP_W   = SPD_W + $clog2(TARGET_STEP + 1) + 1;
	localparam int MUL_CNT_W = $clog2(MPLIER_W + 1);
	localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_RAISE  = 2'd1,
		OP_LOWER  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_RPM_TO_SPEED = 3'd3,
		REG_OUT_MIN      = 3'd4,
		REG_OUT_MAX      = 3'd5,
		REG_SPEED_MIN    = 3'd6,
		REG_SPEED_MAX    = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SPEED,
		ST_INTEG,
		ST_DMUL,
		ST_PMUL,
		ST_IMUL,
		ST_DWAIT,
		ST_ROUND,
		ST_CLAMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [RPM_W-1:0]  motor_rpm;
		logic [TIME_W-1:0] now_ms;
		logic              faulted;
		logic              enabled;
		logic              brake_latched;
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0] throttle;
		logic             drive_valid;
		logic [SPD_W-1:0] target;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [MCAND_W-1:0]  mcand;
		logic [MPLIER_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic              busy;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DT_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/cpt_channels.sv */
// Valid/ready channel interfaces for command items, result items and register writes.
// Payload types come from cpt_pkg.
`default_nettype none

interface cpt_cmd_if;
	import cpt_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cpt_rsp_if;
	import cpt_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cpt_cfg_if;
	import cpt_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cpt_serial_mul.sv */
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Depends on cpt_pkg.
`default_nettype none

module cpt_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  cpt_pkg::mul_req_t req,
	output cpt_pkg::mul_rsp_t rsp
);
	import cpt_pkg::*;

	logic [MCAND_W-1:0]   mcand_q;
	logic [MCAND_W-1:0]   hi_q;
	logic [MPLIER_W-1:0]  lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [MCAND_W:0]     addend;
	logic [MCAND_W:0]     acc;

	// The low half holds the unused multiplier bits; product bits enter from the top.
	always_comb begin
		addend = lo_q[0] ? {mcand_q[MCAND_W-1], mcand_q} : '0;
		acc    = {hi_q[MCAND_W-1], hi_q} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= MUL_CNT_W'(MPLIER_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - MUL_CNT_W'(1);
			if (cnt_q == MUL_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.mcand;
			hi_q    <= '0;
			lo_q    <= req.mplier;
		end else if (busy_q) begin
			hi_q <= acc[MCAND_W:1];
			lo_q <= {acc[0], lo_q[MPLIER_W-1:1]};
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.product = {hi_q, lo_q};

endmodule

`default_nettype wire

/* hw/rtl/cpt_serial_div.sv */
// Restoring divider that yields one quotient bit per cycle for a narrow divisor.
// Unsigned dividend and divisor; depends on cpt_pkg.
`default_nettype none

module cpt_serial_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cpt_pkg::div_req_t req,
	output cpt_pkg::div_rsp_t rsp
);
	import cpt_pkg::*;

	logic [DT_W-1:0]      rem_q;
	logic [DT_W-1:0]      dvs_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DT_W:0]        trial;
	logic [DT_W:0]        trial_sub;
	logic                 fits;

	// Dividend bits leave from the top of quo_q while quotient bits enter at the bottom.
	always_comb begin
		trial     = {rem_q, quo_q[DIVD_W-1]};
		trial_sub = trial - {1'b0, dvs_q};
		fits      = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/cruise_pid_throttle_core.sv */
// Cruise PID throttle core: register file, sequencer and datapath around the serial units.
// Depends on cpt_pkg, cpt_channels, cpt_serial_mul and cpt_serial_div.
//
// One item is taken at a time and each yields one result item. A raise, lower, ignored
// or disengaged sample item goes from DECODE straight to DONE and then back to IDLE. An
// engaged speed sample runs the datapath: the shared bit-serial multiplier makes four
// 16-step passes (speed, derivative product, proportional and integral terms), and the
// 33-step serial divide of the derivative term runs under the last two of them. The
// result register is separate, so a new item can be accepted while a result waits.
`default_nettype none

module cruise_pid_throttle_core (
	input  logic        clk,
	input  logic        arst_n,
	cpt_cmd_if.sink     cmd,
	cpt_rsp_if.source   rsp,
	cpt_cfg_if.sink     cfg
);
	import cpt_pkg::*;

	localparam logic signed [D100_W-1:0] D_SCALE_S = D100_W'(D_SCALE);

	state_t state_q, state_nxt;

	// Configuration
	logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [OUT_W-1:0]   out_min_q, out_max_q;
	logic [SPD_W-1:0]   speed_min_q, speed_max_q;

	// Loop state
	logic [SPD_W-1:0]  target_q;
	logic [TIME_W-1:0] last_time_q;
	logic [INT_W-1:0]  integ_q;
	logic [ERR_W-1:0]  last_err_q;

	// Item and work registers
	logic [1:0]        op_q;
	logic [RPM_W-1:0]  rpm_q;
	logic [TIME_W-1:0] now_q;
	logic              engaged_q;
	logic [ERR_W-1:0]  err_q;
	logic [DT_W-1:0]   dt_q;
	logic              d_neg_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SCL_W-1:0]  scl_q;
	logic [OUT_W-1:0]  res_thr_q;
	logic              res_dv_q;
	rsp_t              out_q;
	logic              out_vld_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                   cmd_take;
	logic                   out_load;
	logic                   is_engaged_sample;
	logic [RPM_W-1:0]       speed;
	logic signed [RPM_W:0]  err_raw;
	logic [ERR_W-1:0]       err_sat;
	logic [TIME_W-1:0]      tdiff;
	logic [DT_W-1:0]        dt_calc;
	logic signed [ED_W-1:0] err_dt;
	logic signed [INT_W:0]  isum;
	logic [INT_W-1:0]       integ_next;
	logic signed [D100_W-1:0] dx;
	logic signed [D100_W-1:0] d100;
	logic [PROD_W-1:0]      prod_abs;
	logic [SUM_W-1:0]       prod_ext;
	logic [SUM_W-1:0]       d_term;
	logic [SUM_W-1:0]       rsum;
	logic [OUT_W-1:0]       clamp_val;
	logic [STEP_W-1:0]      raise_sum;
	logic signed [STEP_W-1:0] lower_sum;
	logic [SPD_W-1:0]       raise_val;
	logic [SPD_W-1:0]       lower_val;

	assign cmd_take          = cmd.valid && cmd.ready;
	assign out_load          = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);
	assign is_engaged_sample = (op_q == OP_SAMPLE) && engaged_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (cmd.valid) state_nxt = ST_DECODE;
			ST_DECODE: state_nxt = is_engaged_sample ? ST_SPEED : ST_DONE;
			ST_SPEED:  if (!mul_rsp.busy) state_nxt = ST_INTEG;
			ST_INTEG:  state_nxt = ST_DMUL;
			ST_DMUL:   if (!mul_rsp.busy) state_nxt = ST_PMUL;
			ST_PMUL:   if (!mul_rsp.busy) state_nxt = ST_IMUL;
			ST_IMUL:   if (!mul_rsp.busy) state_nxt = ST_DWAIT;
			ST_DWAIT:  if (!div_rsp.busy) state_nxt = ST_ROUND;
			ST_ROUND:  state_nxt = ST_CLAMP;
			ST_CLAMP:  state_nxt = ST_DONE;
			ST_DONE:   if (!out_vld_q || rsp.ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and requests to the serial units
	always_comb begin
		cmd.ready       = (state_q == ST_IDLE);
		mul_req         = '0;
		div_req         = '0;
		div_req.dividend = prod_abs[DIVD_W-1:0];
		div_req.divisor  = dt_q;
		case (state_q)
			ST_DECODE: begin
				mul_req.start  = is_engaged_sample;
				mul_req.mcand  = MCAND_W'(rpm_q);
				mul_req.mplier = MPLIER_W'(ratio_q);
			end
			ST_INTEG: begin
				mul_req.start  = 1'b1;
				mul_req.mcand  = MCAND_W'(d100);
				mul_req.mplier = gain_d_q;
			end
			ST_DMUL: begin
				mul_req.start  = !mul_rsp.busy;
				mul_req.mcand  = MCAND_W'($signed(err_q));
				mul_req.mplier = gain_p_q;
				div_req.start  = !mul_rsp.busy;
			end
			ST_PMUL: begin
				mul_req.start  = !mul_rsp.busy;
				mul_req.mcand  = integ_q;
				mul_req.mplier = gain_i_q;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	// Datapath arithmetic
	always_comb begin
		speed   = mul_rsp.product[RATIO_W +: RPM_W];
		err_raw = $signed({{(RPM_W + 1 - SPD_W){1'b0}}, target_q}) - $signed({1'b0, speed});
		if (err_raw > $signed((RPM_W + 1)'(2 ** (ERR_W - 1) - 1))) begin
			err_sat = {1'b0, {(ERR_W - 1){1'b1}}};
		end else if (err_raw < $signed(-(RPM_W + 1)'(2 ** (ERR_W - 1)))) begin
			err_sat = {1'b1, {(ERR_W - 1){1'b0}}};
		end else begin
			err_sat = err_raw[ERR_W-1:0];
		end

		// Long gaps fall back to a nominal period, and a repeated timestamp counts as one.
		tdiff = now_q - last_time_q;
		if (tdiff > TIME_W'(DT_LIMIT)) begin
			dt_calc = DT_W'(DT_REPLACE);
		end else if (tdiff == '0) begin
			dt_calc = DT_W'(1);
		end else begin
			dt_calc = tdiff[DT_W-1:0];
		end

		err_dt = ED_W'($signed(err_q)) * ED_W'($signed({1'b0, dt_q}));
		isum   = (INT_W + 1)'($signed(integ_q)) + (INT_W + 1)'(err_dt);
		if (isum[INT_W] != isum[INT_W-1]) begin
			integ_next = isum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
		end else begin
			integ_next = isum[INT_W-1:0];
		end

		dx   = D100_W'($signed(err_q)) - D100_W'($signed(last_err_q));
		d100 = dx * D_SCALE_S;

		prod_abs = mul_rsp.product[PROD_W-1] ? (~mul_rsp.product + PROD_W'(1)) : mul_rsp.product;
		prod_ext = SUM_W'($signed(mul_rsp.product));
		d_term   = d_neg_q ? (~SUM_W'(div_rsp.quotient) + SUM_W'(1)) : SUM_W'(div_rsp.quotient);

		// Bias negative sums so the shift truncates toward zero.
		rsum = sum_q + (sum_q[SUM_W-1] ? SUM_W'(2 ** FRAC_W - 1) : '0);

		if ($signed(scl_q) > $signed({{(SCL_W - OUT_W){1'b0}}, out_max_q})) begin
			clamp_val = out_max_q;
		end else if ($signed(scl_q) < $signed({{(SCL_W - OUT_W){1'b0}}, out_min_q})) begin
			clamp_val = out_min_q;
		end else begin
			clamp_val = scl_q[OUT_W-1:0];
		end

		raise_sum = STEP_W'(target_q) + STEP_W'(TARGET_STEP);
		raise_val = (raise_sum > STEP_W'(speed_max_q)) ? speed_max_q : raise_sum[SPD_W-1:0];
		lower_sum = $signed(STEP_W'(target_q)) - $signed(STEP_W'(TARGET_STEP));
		lower_val = (lower_sum < $signed(STEP_W'(speed_min_q))) ? speed_min_q
			: lower_sum[SPD_W-1:0];
	end

	// Control, configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			ratio_q     <= '0;
			out_min_q   <= '0;
			out_max_q   <= '1;
			speed_min_q <= '0;
			speed_max_q <= '1;
			target_q    <= '0;
			last_time_q <= '0;
			integ_q     <= '0;
			last_err_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.data.index))
					REG_GAIN_P:       gain_p_q    <= cfg.data.value[GAIN_W-1:0];
					REG_GAIN_I:       gain_i_q    <= cfg.data.value[GAIN_W-1:0];
					REG_GAIN_D:       gain_d_q    <= cfg.data.value[GAIN_W-1:0];
					REG_RPM_TO_SPEED: ratio_q     <= cfg.data.value[RATIO_W-1:0];
					REG_OUT_MIN:      out_min_q   <= cfg.data.value[OUT_W-1:0];
					REG_OUT_MAX:      out_max_q   <= cfg.data.value[OUT_W-1:0];
					REG_SPEED_MIN:    speed_min_q <= cfg.data.value[SPD_W-1:0];
					REG_SPEED_MAX:    speed_max_q <= cfg.data.value[SPD_W-1:0];
					default:          gain_p_q    <= gain_p_q;
				endcase
			end

			if (state_q == ST_DECODE) begin
				case (op_q)
					OP_SAMPLE: if (!engaged_q) integ_q <= '0;
					OP_RAISE:  target_q <= raise_val;
					OP_LOWER:  target_q <= lower_val;
					default:   target_q <= target_q;
				endcase
			end

			if (state_q == ST_INTEG) begin
				integ_q     <= integ_next;
				last_time_q <= now_q;
				last_err_q  <= err_q;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q      <= cmd.data.opcode;
			rpm_q     <= cmd.data.motor_rpm;
			now_q     <= cmd.data.now_ms;
			engaged_q <= !cmd.data.faulted && cmd.data.enabled && !cmd.data.brake_latched;
		end
		if (state_q == ST_DECODE) begin
			dt_q      <= dt_calc;
			res_thr_q <= '0;
			res_dv_q  <= 1'b0;
		end
		if ((state_q == ST_SPEED) && !mul_rsp.busy) begin
			err_q <= err_sat;
		end
		if ((state_q == ST_DMUL) && !mul_rsp.busy) begin
			d_neg_q <= mul_rsp.product[PROD_W-1];
		end
		if ((state_q == ST_PMUL) && !mul_rsp.busy) begin
			sum_q <= prod_ext;
		end
		if ((state_q == ST_IMUL) && !mul_rsp.busy) begin
			sum_q <= sum_q + prod_ext;
		end
		if ((state_q == ST_DWAIT) && !div_rsp.busy) begin
			sum_q <= sum_q + d_term;
		end
		if (state_q == ST_ROUND) begin
			scl_q <= rsum[SUM_W-1:FRAC_W];
		end
		if (state_q == ST_CLAMP) begin
			res_thr_q <= clamp_val;
			res_dv_q  <= 1'b1;
		end
		if (out_load) begin
			out_q.throttle    <= res_thr_q;
			out_q.drive_valid <= res_dv_q;
			out_q.target      <= target_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;
	assign cfg.ready = 1'b1;

	cpt_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	cpt_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

/* hw/rtl/cpt_checker.sv */
// Port-level checker for the cruise PID throttle core and the bind that attaches it.
// Depends on cpt_pkg and cruise_pid_throttle_core.
`default_nettype none

module cpt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input cpt_pkg::rsp_t rsp_data
);
	import cpt_pkg::*;

	logic [1:0] pend_q;
	logic       cmd_take;
	logic       rsp_take;

	assign cmd_take = cmd_valid && cmd_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// Items accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, cmd_take} - {1'b0, rsp_take};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result item changed while stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.drive_valid |-> rsp_data.throttle == '0)
		else $error("throttle not zero on a result without drive");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result item without an accepted item");

	a_one_in_core: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> pend_q <= 2'd1)
		else $error("item accepted while the core is still busy");

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> !cmd_ready)
		else $error("ready stayed high after an item was taken");

endmodule

bind cruise_pid_throttle_core cpt_checker u_cpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for cruise_pid_throttle_core: a table of directed items, then random phases.
// Depends on cpt_pkg and the channel interfaces in cpt_channels, and on the core itself.

module tb;
	import cpt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Flag triples in the order {faulted, enabled, brake_latched}.
	localparam logic [2:0] FL_ENGAGED = 3'b010;
	localparam logic [2:0] FL_OFF     = 3'b000;
	localparam logic [2:0] FL_FAULT   = 3'b110;
	localparam logic [2:0] FL_BRAKE   = 3'b011;
	localparam logic [2:0] FL_ALL     = 3'b111;

	localparam longint ERR_LO = -(64'sd1 <<< (ERR_W - 1));
	localparam longint ERR_HI = (64'sd1 <<< (ERR_W - 1)) - 1;
	localparam longint ACC_LO = -(64'sd1 <<< (INT_W - 1));
	localparam longint ACC_HI = (64'sd1 <<< (INT_W - 1)) - 1;
	localparam longint Q_ONE  = 64'sd1 <<< FRAC_W;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 192;
	localparam int LONG_HOLD       = 300;
	localparam int END_WAIT        = 100;
	localparam int WATCHDOG_LIMIT  = 4000;

	typedef struct {
		bit                    is_cfg;
		cmd_t                  cmd;
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] value;
		bit                    fixed;
		rsp_t                  want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cpt_cmd_if cmd_ch ();
	cpt_rsp_if rsp_ch ();
	cpt_cfg_if cfg_ch ();

	cruise_pid_throttle_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	wire cmd_fire = cmd_ch.valid && cmd_ch.ready;
	wire rsp_fire = rsp_ch.valid && rsp_ch.ready;
	wire cfg_fire = cfg_ch.valid && cfg_ch.ready;

	// Register copies and loop state of the predictor.
	longint            reg_shadow [8] = '{0, 0, 0, 0, 0, 65535, 0, 255};
	longint            cruise_target = 0;
	logic [TIME_W-1:0] seen_ms = '0;
	longint            integ_acc = 0;
	longint            prev_err = 0;

	rsp_t cruise_due [$];
	plan_row_t plan [$];

	bit tx_idle  = 1'b1;
	bit rx_idle  = 1'b1;
	bit hold_req = 1'b0;

	int errors      = 0;
	int checked     = 0;
	int items_sent  = 0;
	int engaged_cnt = 0;
	int reg_writes  = 0;
	int holds_done  = 0;

	logic [TIME_W-1:0] sim_ms = '0;

	function automatic rsp_t cruise_predict(cmd_t c);
		rsp_t              r;
		logic [TIME_W-1:0] gap;
		longint            speed, err, dt, sum, next_t;
		r = '0;
		case (c.opcode)
			OP_SAMPLE: begin
				if (!c.faulted && c.enabled && !c.brake_latched) begin
					engaged_cnt++;
					speed = c.motor_rpm;
					speed = (speed * reg_shadow[REG_RPM_TO_SPEED]) >>> 16;
					err = cruise_target - speed;
					if (err < ERR_LO) err = ERR_LO;
					if (err > ERR_HI) err = ERR_HI;
					gap = c.now_ms - seen_ms;
					dt = gap;
					if (gap > DT_LIMIT) dt = DT_REPLACE;
					if (dt == 0) dt = 1;
					seen_ms = c.now_ms;
					integ_acc = integ_acc + err * dt;
					if (integ_acc < ACC_LO) integ_acc = ACC_LO;
					if (integ_acc > ACC_HI) integ_acc = ACC_HI;
					// Signed division truncates toward zero on both the derivative and the scale-down.
					sum = (reg_shadow[REG_GAIN_P] * err + reg_shadow[REG_GAIN_I] * integ_acc
						+ (reg_shadow[REG_GAIN_D] * D_SCALE * (err - prev_err)) / dt) / Q_ONE;
					prev_err = err;
					if (sum > reg_shadow[REG_OUT_MAX]) sum = reg_shadow[REG_OUT_MAX];
					else if (sum < reg_shadow[REG_OUT_MIN]) sum = reg_shadow[REG_OUT_MIN];
					r.throttle = sum[OUT_W-1:0];
					r.drive_valid = 1'b1;
				end else begin
					integ_acc = 0;
				end
			end
			OP_RAISE: begin
				next_t = cruise_target + TARGET_STEP;
				if (next_t > reg_shadow[REG_SPEED_MAX]) next_t = reg_shadow[REG_SPEED_MAX];
				cruise_target = next_t;
			end
			OP_LOWER: begin
				next_t = cruise_target - TARGET_STEP;
				if (next_t < reg_shadow[REG_SPEED_MIN]) next_t = reg_shadow[REG_SPEED_MIN];
				cruise_target = next_t;
			end
			default: ;
		endcase
		r.target = cruise_target[SPD_W-1:0];
		return r;
	endfunction

	function automatic rsp_t result_of(logic [OUT_W-1:0] thr, logic dv, logic [SPD_W-1:0] tgt);
		rsp_t r;
		r.throttle = thr;
		r.drive_valid = dv;
		r.target = tgt;
		return r;
	endfunction

	function automatic plan_row_t item_row(logic [1:0] op, logic [RPM_W-1:0] rpm,
			logic [TIME_W-1:0] now, logic [2:0] flags, bit fixed = 1'b0, rsp_t want = '0);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.cmd.opcode = op;
		row.cmd.motor_rpm = rpm;
		row.cmd.now_ms = now;
		row.cmd.faulted = flags[2];
		row.cmd.enabled = flags[1];
		row.cmd.brake_latched = flags[0];
		row.idx = REG_GAIN_P;
		row.value = '0;
		row.fixed = fixed;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.cmd = '0;
		row.idx = idx;
		row.value = value;
		row.fixed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	task automatic report_diff(string what, longint got, longint want);
		errors++;
		if (errors <= 40)
			$display("ERROR at %0t, result %0d: %s is %0d, expected %0d", $time, checked, what,
				got, want);
	endtask

	// Offers one command item, waits for it to be taken and queues its expected result.
	task automatic send_item(cmd_t c, bit fixed, rsp_t want);
		rsp_t pred;
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_ch.data <= c;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pred = cruise_predict(c);
		cruise_due.push_back(fixed ? want : pred);
		items_sent++;
	endtask

	// The caller lowers the write valid after the last write of a batch.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_t w;
		w.index = idx;
		w.value = value;
		cfg_ch.data <= w;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		reg_shadow[idx] = (idx == REG_SPEED_MIN || idx == REG_SPEED_MAX) ? value[7:0] : value;
		reg_writes++;
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (cruise_due.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_fire) begin
			checked++;
			if (cruise_due.size() == 0) begin
				report_diff("unexpected item, throttle", rsp_ch.data.throttle, 0);
			end else begin
				want = cruise_due.pop_front();
				if (rsp_ch.data.throttle !== want.throttle)
					report_diff("throttle", rsp_ch.data.throttle, want.throttle);
				if (rsp_ch.data.drive_valid !== want.drive_valid)
					report_diff("drive_valid", rsp_ch.data.drive_valid, want.drive_valid);
				if (rsp_ch.data.target !== want.target)
					report_diff("target", rsp_ch.data.target, want.target);
			end
		end
	end

	initial begin : rsp_sink
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_ch.ready <= 1'b1;
				hold_req = 1'b0;
				holds_done++;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cmd_fire || rsp_fire || cfg_fire) quiet = 0;
			else quiet++;
		end
		$display("Timed out: no item moved for %0d cycles.", WATCHDOG_LIMIT);
		$display("cruise_pid_throttle_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		cmd_t              c;
		int                pick;
		longint            aim;
		logic [2:0]        fl;
		logic [15:0]       lo, hi, tmp;
		logic [15:0]       regs_next [8];

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;

		// Reset settings: all gains and the ratio are zero, so every engaged throttle is zero.
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd0, FL_ENGAGED, 1, result_of(0, 1, 0)));
		plan.push_back(item_row(OP_LOWER, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 0)));
		plan.push_back(item_row(OP_RAISE, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 1)));
		plan.push_back(item_row(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, FL_ALL, 1,
			result_of(0, 0, 1)));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, FL_FAULT, 1,
			result_of(0, 0, 1)));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, FL_OFF, 1,
			result_of(0, 0, 1)));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, FL_BRAKE, 1,
			result_of(0, 0, 1)));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, FL_ENGAGED, 1,
			result_of(0, 1, 1)));
		// Moderate gains: wrapped elapsed time, zero elapsed time, the limit and just past it.
		plan.push_back(cfg_row(REG_GAIN_P, 16'd256));
		plan.push_back(cfg_row(REG_GAIN_I, 16'd16));
		plan.push_back(cfg_row(REG_GAIN_D, 16'd64));
		plan.push_back(cfg_row(REG_RPM_TO_SPEED, 16'h1000));
		plan.push_back(item_row(OP_RAISE, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 2)));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd4, FL_ENGAGED));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd4, FL_ENGAGED));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd24, FL_ENGAGED));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd45, FL_ENGAGED));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'd50, FL_ENGAGED));
		// Throttle floor above the ceiling, and a speed floor above the target.
		plan.push_back(cfg_row(REG_OUT_MIN, 16'd40000));
		plan.push_back(cfg_row(REG_OUT_MAX, 16'd100));
		plan.push_back(cfg_row(REG_SPEED_MIN, 16'd200));
		plan.push_back(cfg_row(REG_GAIN_I, 16'hFFFF));
		plan.push_back(item_row(OP_LOWER, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 200)));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd60, FL_ENGAGED));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'd70, FL_ENGAGED));
		plan.push_back(cfg_row(REG_SPEED_MAX, 16'd10));
		plan.push_back(item_row(OP_RAISE, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 10)));
		plan.push_back(cfg_row(REG_SPEED_MIN, 16'd255));
		plan.push_back(cfg_row(REG_SPEED_MAX, 16'd255));
		plan.push_back(item_row(OP_LOWER, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 255)));
		plan.push_back(item_row(OP_RAISE, 16'd0, 32'd0, FL_OFF, 1, result_of(0, 0, 255)));
		// Full-scale gains and ratio: the sums pin to the throttle limits.
		plan.push_back(cfg_row(REG_GAIN_P, 16'hFFFF));
		plan.push_back(cfg_row(REG_GAIN_D, 16'hFFFF));
		plan.push_back(cfg_row(REG_RPM_TO_SPEED, 16'hFFFF));
		plan.push_back(cfg_row(REG_OUT_MIN, 16'd0));
		plan.push_back(cfg_row(REG_OUT_MAX, 16'hFFFF));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd75, FL_OFF, 1, result_of(0, 0, 255)));
		plan.push_back(item_row(OP_SAMPLE, 16'd0, 32'd80, FL_ENGAGED, 1,
			result_of(16'hFFFF, 1, 255)));
		plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 32'd80, FL_ENGAGED, 1,
			result_of(0, 1, 255)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				if (k == 0 || !plan[k-1].is_cfg) drain_results();
				write_reg(plan[k].idx, plan[k].value);
				if (k == plan.size() - 1 || !plan[k+1].is_cfg) cfg_ch.valid <= 1'b0;
			end else begin
				send_item(plan[k].cmd, plan[k].fixed, plan[k].want);
			end
		end

		sim_ms = 32'd80;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			tx_idle = (ph != PHASES - 1);
			rx_idle = (ph != PHASES - 1);
			if (ph == 0) begin
				foreach (regs_next[r]) regs_next[r] = 16'h0000;
			end else if (ph == 1) begin
				foreach (regs_next[r]) regs_next[r] = 16'hFFFF;
			end else begin
				regs_next[REG_GAIN_P] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 1024));
				regs_next[REG_GAIN_I] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 64));
				regs_next[REG_GAIN_D] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 256));
				regs_next[REG_RPM_TO_SPEED] = 16'($urandom);
				lo = 16'($urandom_range(0, 30000));
				hi = 16'($urandom_range(lo, 65535));
				if ($urandom_range(0, 5) == 0) begin
					tmp = lo;
					lo = hi;
					hi = tmp;
				end
				regs_next[REG_OUT_MIN] = lo;
				regs_next[REG_OUT_MAX] = hi;
				// Upper byte of the speed limits is junk that the core must drop.
				lo = {8'($urandom), 8'($urandom_range(0, 60))};
				hi = {8'($urandom), 8'($urandom_range(80, 255))};
				if ($urandom_range(0, 5) == 0) begin
					tmp = lo;
					lo = hi;
					hi = tmp;
				end
				regs_next[REG_SPEED_MIN] = lo;
				regs_next[REG_SPEED_MAX] = hi;
			end
			for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), regs_next[r]);
			cfg_ch.valid <= 1'b0;

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Starve the result side for a long stretch while items keep coming.
				if (ph == 3 && i == 40) hold_req = 1'b1;
				c.motor_rpm = 16'($urandom);
				c.now_ms = $urandom;
				fl = 3'($urandom_range(0, 7));
				pick = $urandom_range(0, 99);
				if (pick < 68) begin
					c.opcode = OP_SAMPLE;
					if (pick < 60) begin
						fl = FL_ENGAGED;
					end else begin
						while (fl == FL_ENGAGED) fl = 3'($urandom_range(0, 7));
					end
					if ($urandom_range(0, 99) < 85) sim_ms = sim_ms + $urandom_range(0, 24);
					else sim_ms = $urandom;
					c.now_ms = sim_ms;
					// Half the samples sit near the target when the ratio is nonzero, so the error stays small.
					if (reg_shadow[REG_RPM_TO_SPEED] != 0 && $urandom_range(0, 1) == 1) begin
						aim = cruise_target + longint'($urandom_range(0, 20)) - 10;
						if (aim < 0) aim = 0;
						aim = (aim * 65536) / reg_shadow[REG_RPM_TO_SPEED];
						if (aim > 65535) aim = 65535;
						c.motor_rpm = aim[RPM_W-1:0];
					end
				end else if (pick < 82) begin
					c.opcode = OP_RAISE;
				end else if (pick < 96) begin
					c.opcode = OP_LOWER;
				end else begin
					c.opcode = OP_UNUSED;
				end
				c.faulted = fl[2];
				c.enabled = fl[1];
				c.brake_latched = fl[0];
				send_item(c, 1'b0, '0);
			end
		end

		drain_results();
		repeat (END_WAIT) @(posedge clk);
		$display("Run covered %0d items, %0d of them engaged samples, with %0d register writes.",
			items_sent, engaged_cnt, reg_writes);
		$display("Checked %0d result items, %0d long receiver hold-offs, %0d errors.",
			checked, holds_done, errors);
		if (errors == 0 && cruise_due.size() == 0) begin
			$display("cruise_pid_throttle_core: match");
		end else begin
			$display("cruise_pid_throttle_core: mismatch");
		end
		$finish;
	end

endmodule
